### hdl/stpm_pkg.sv
// Shared codes and types for the sorted table pointer mark engine.
`timescale 1ns / 1ps

package stpm_pkg;

  // item operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // pointer tag bits that never belong to an object address
  localparam int PTR_LOW_BITS = 2;

  // compare flags from the shared step unit
  typedef struct packed {
    logic le;    // entry <= candidate
    logic eq;    // entry == candidate
    logic more;  // search window still wider than one entry
  } stpm_flags_t;

endpackage

### hdl/stpm_if.sv
// Request and response channel interfaces of the pointer mark engine.
`timescale 1ns / 1ps

interface stpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] word;
  logic [11:0] entry_index;

  modport source (output valid, output op, output word, output entry_index, input ready);
  modport sink   (input valid, input op, input word, input entry_index, output ready);
endinterface

interface stpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [11:0] found_index;
  logic [63:0] entry_address;
  logic        marked;

  modport source (output valid, output status, output hit, output found_index,
                  output entry_address, output marked, input ready);
  modport sink   (input valid, input status, input hit, input found_index,
                  input entry_address, input marked, output ready);
endinterface

### hdl/stpm_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module stpm_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/stpm_step.sv
// Shared search step unit: address compare and window midpoint.
`timescale 1ns / 1ps

module stpm_step #(
  parameter int ADDR_WIDTH = 64,
  parameter int CW         = 13
) (
  input  logic [ADDR_WIDTH-1:0] entry,
  input  logic [ADDR_WIDTH-1:0] cand,
  input  logic [CW-1:0]         lo,
  input  logic [CW-1:0]         hi,
  output stpm_pkg::stpm_flags_t flags,
  output logic [CW-1:0]         mid
);
  import stpm_pkg::*;

  logic [CW:0]   sum;
  logic [CW-1:0] span;

  assign sum  = {1'b0, lo} + {1'b0, hi};
  assign mid  = sum[CW:1];
  assign span = hi - lo;

  assign flags.le   = (entry <= cand);
  assign flags.eq   = (entry == cand);
  assign flags.more = (span > CW'(1));

endmodule

### hdl/sorted_table_pointer_mark.sv
// Top level of the sorted table pointer mark engine.
`timescale 1ns / 1ps
// One item at a time; the next item is taken once the result is in the output
//   register. Each search step issues a table RAM read in S_MID and narrows the
//   window in S_STEP on the registered read data.
// Reset (rst, synchronous) clears the sequencer, entry count and output valid.
//   No clearing pass: marks ride in the table and are zeroed as entries load.

module sorted_table_pointer_mark #(
  parameter int TABLE_DEPTH = 4096,
  parameter int ADDR_WIDTH  = 64
) (
  input logic       clk,
  input logic       rst,
  stpm_req_if.sink  req,
  stpm_rsp_if.source rsp
);
  import stpm_pkg::*;

  localparam int IW   = $clog2(TABLE_DEPTH);      // table index bits
  localparam int CW   = $clog2(TABLE_DEPTH + 1);  // entry count bits
  localparam int CMPW = (CW > 12) ? CW : 12;      // read index compare width
  localparam int RW   = ADDR_WIDTH + 1;           // mark bit on top of address

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LO_CHK = 4'd1;  // first entry back, check lower bound
  localparam logic [3:0] S_HI_CHK = 4'd2;  // last entry back, check upper bound
  localparam logic [3:0] S_MID    = 4'd3;  // pick next probe point or finish
  localparam logic [3:0] S_STEP   = 4'd4;  // midpoint entry back, narrow window
  localparam logic [3:0] S_FIND   = 4'd5;  // floor entry back, exact match test
  localparam logic [3:0] S_RDATA  = 4'd6;  // read-back data
  localparam logic [3:0] S_FIN    = 4'd7;  // hand result to output register

  logic [3:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         mid_q;
  logic [ADDR_WIDTH-1:0] cand;
  logic [11:0]           idx_q;

  // pending result
  logic [1:0]  p_status;
  logic        p_hit;
  logic [11:0] p_found;
  logic [63:0] p_addr;
  logic        p_marked;

  // output register
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_hit;
  logic [11:0] out_found;
  logic [63:0] out_addr;
  logic        out_marked;

  // table RAM: {mark, address} per entry
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  stpm_flags_t   flags;
  logic [CW-1:0] mid;

  logic                  req_acc;
  logic                  full;
  logic                  rd_ok;
  logic [ADDR_WIDTH-1:0] clean_word;
  logic [CMPW-1:0]       idx_ext;
  logic [CW-1:0]         last;

  assign req_acc    = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign full       = (count == CW'(TABLE_DEPTH));
  assign idx_ext    = CMPW'(req.entry_index);
  assign rd_ok      = (idx_ext < CMPW'(count));
  assign last       = count - CW'(1);
  // keep ADDR_WIDTH bits, drop the pointer tag bits
  assign clean_word = {req.word[ADDR_WIDTH-1:PTR_LOW_BITS], {PTR_LOW_BITS{1'b0}}};

  stpm_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stpm_step #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .CW         (CW)
  ) u_step (
    .entry (ram_rdata[ADDR_WIDTH-1:0]),
    .cand  (cand),
    .lo    (lo),
    .hi    (hi),
    .flags (flags),
    .mid   (mid)
  );

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IW-1:0];
    ram_wdata = {1'b0, clean_word};
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (req_acc && req.op == OP_LOAD && !full) begin
          ram_we = 1'b1;  // fresh entry, mark cleared
        end
        if (req_acc && req.op == OP_PROBE) begin
          ram_re = 1'b1;  // first entry
        end
        if (req_acc && req.op == OP_READ) begin
          ram_re    = 1'b1;
          ram_raddr = idx_ext[IW-1:0];
        end
      end
      S_LO_CHK: begin
        ram_re    = 1'b1;
        ram_raddr = last[IW-1:0];
      end
      S_MID: begin
        ram_re    = 1'b1;
        ram_raddr = flags.more ? mid[IW-1:0] : lo[IW-1:0];
      end
      S_FIND: begin
        if (flags.eq) begin
          ram_we    = 1'b1;  // set mark, address unchanged
          ram_waddr = lo[IW-1:0];
          ram_wdata = {1'b1, cand};
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_FIN a taken result is replaced by the next one below
      if (out_valid && rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            p_status <= ST_OK;
            p_hit    <= 1'b0;
            p_found  <= '0;
            p_addr   <= '0;
            p_marked <= 1'b0;
            cand     <= clean_word;
            idx_q    <= req.entry_index;
            lo       <= '0;
            hi       <= count;
            state    <= S_FIN;
            case (req.op)
              OP_CLEAR: begin
                count <= '0;
              end
              OP_LOAD: begin
                if (full) begin
                  p_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_PROBE: begin
                if (count != '0) begin
                  state <= S_LO_CHK;
                end
              end
              default: begin  // read entry
                if (rd_ok) begin
                  state <= S_RDATA;
                end else begin
                  p_status <= ST_RANGE;
                end
              end
            endcase
          end
        end
        S_LO_CHK: begin
          state <= flags.le ? S_HI_CHK : S_FIN;
        end
        S_HI_CHK: begin
          // candidate above the last entry: miss
          state <= (!flags.le || flags.eq) ? S_MID : S_FIN;
        end
        S_MID: begin
          mid_q <= mid;
          state <= flags.more ? S_STEP : S_FIND;
        end
        S_STEP: begin
          if (flags.le) begin
            lo <= mid_q;
          end else begin
            hi <= mid_q;
          end
          state <= S_MID;
        end
        S_FIND: begin
          if (flags.eq) begin
            p_hit    <= 1'b1;
            p_found  <= 12'(lo);
            p_marked <= 1'b1;
          end
          state <= S_FIN;
        end
        S_RDATA: begin
          p_found  <= idx_q;
          p_addr   <= 64'(ram_rdata[ADDR_WIDTH-1:0]);
          p_marked <= ram_rdata[ADDR_WIDTH];
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= p_status;
            out_hit    <= p_hit;
            out_found  <= p_found;
            out_addr   <= p_addr;
            out_marked <= p_marked;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.hit           = out_hit;
  assign rsp.found_index   = out_found;
  assign rsp.entry_address = out_addr;
  assign rsp.marked        = out_marked;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID || state == S_STEP || state == S_FIND) |-> (lo < hi && hi <= count))
    else $error("search window broken");

  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (mid_q > lo && mid_q < hi))
    else $error("probe point outside window");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.op == OP_LOAD && !full) |=> (count == $past(count) + CW'(1)))
    else $error("load did not advance entry count");

  a_hit_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_hit) |-> (out_marked && out_status == ST_OK))
    else $error("hit without mark or with error status");
`endif

endmodule

### test/sorted_table_pointer_mark_checker.sv
// Channel monitor, mark table predictor and result comparison for the pointer mark engine.
`timescale 1ns / 1ps

module sorted_table_pointer_mark_checker #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic clk,
  input  logic rst,
  stpm_req_if  req,
  stpm_rsp_if  rsp,
  output int   fails,
  output int   pending
);
  import stpm_pkg::*;

  localparam logic [63:0] TAG_MASK = ~((64'd1 << PTR_LOW_BITS) - 64'd1);

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [11:0] found_index;
    logic [63:0] entry_address;
    logic        marked;
  } mark_answer_t;

  // shadow of the engine: addresses, marks and fill level
  logic [63:0]            addr_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] mark_tab;
  logic [12:0]            loaded_cnt;

  mark_answer_t answers_due[$];
  mark_answer_t want;
  int           errors = 0;
  int           answers_seen = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (errors < 40)
      $display("%0t ns result %0d: %s got %0h, want %0h", $time, answers_seen, what,
               got, exp_val);
    errors++;
  endtask

  // Applies one item to the shadow state and returns the answer it must produce.
  function automatic mark_answer_t mark_engine_answer(input logic [1:0] op,
                                                      input logic [63:0] w,
                                                      input logic [11:0] ix);
    mark_answer_t a;
    logic [63:0]  cand;
    int           lo, hi, mid;
    a = '0;
    cand = w & TAG_MASK;
    case (op)
      OP_CLEAR: begin
        mark_tab = '0;
        loaded_cnt = '0;
      end
      OP_LOAD: begin
        if (loaded_cnt >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          addr_tab[loaded_cnt] = cand;
          mark_tab[loaded_cnt] = 1'b0;
          loaded_cnt++;
        end
      end
      OP_PROBE: begin
        if (loaded_cnt != 0 && cand >= addr_tab[0] && cand <= addr_tab[loaded_cnt - 1]) begin
          lo = 0;
          hi = loaded_cnt;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (addr_tab[mid] <= cand) lo = mid;
            else hi = mid;
          end
          if (addr_tab[lo] == cand) begin
            mark_tab[lo] = 1'b1;
            a.hit = 1'b1;
            a.found_index = lo[11:0];
            a.marked = 1'b1;
          end
        end
      end
      default: begin
        if (ix < loaded_cnt) begin
          a.found_index = ix;
          a.entry_address = addr_tab[ix];
          a.marked = mark_tab[ix];
        end else begin
          a.status = ST_RANGE;
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      answers_due.delete();
      mark_tab = '0;
      loaded_cnt = '0;
    end else begin
      // a result leaving now belongs to an item taken at an earlier edge
      if (rsp.valid && rsp.ready) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.hit !== want.hit)
            report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
          if (rsp.found_index !== want.found_index)
            report_mismatch("found_index", 64'(rsp.found_index), 64'(want.found_index));
          if (rsp.entry_address !== want.entry_address)
            report_mismatch("entry_address", rsp.entry_address, want.entry_address);
          if (rsp.marked !== want.marked)
            report_mismatch("marked", 64'(rsp.marked), 64'(want.marked));
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(mark_engine_answer(req.op, req.word, req.entry_index));
    end
    pending <= answers_due.size();
    fails <= errors;
  end

endmodule

### test/sorted_table_pointer_mark_tb.sv
// Stimulus, handshake idling and verdict for the pointer mark engine testbench.
`timescale 1ns / 1ps

module sorted_table_pointer_mark_tb;
  import stpm_pkg::*;

  localparam int          TABLE_DEPTH = 4096;
  localparam int          RANDOM_ITEMS = 1350;
  // longest correct quiet spell: a sender gap, a probe and a sink stall, well under this
  localparam int          STALL_LIMIT = 2000;
  localparam logic [63:0] TAG_MASK = ~((64'd1 << PTR_LOW_BITS) - 64'd1);

  typedef enum int { SINK_OPEN, SINK_RANDOM, SINK_BURSTY } sink_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;

  stpm_req_if req_ch ();
  stpm_rsp_if rsp_ch ();

  sorted_table_pointer_mark #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (64)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_table_pointer_mark_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Result sink: switches between always ready, ready three times in four and long
  // stall runs, so back-pressure lands on every phase of a search.
  // ---------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         hold_left = 0;
  logic       hold_low = 1'b0;

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(50, 400);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:   rsp_ch.ready <= 1'b1;
      SINK_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_low = !hold_low;
          hold_left = hold_low ? $urandom_range(1, 24) : $urandom_range(1, 8);
        end
        hold_left--;
        rsp_ch.ready <= !hold_low;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Item sender. Bursts of random length; between most bursts valid drops for a
  // random gap. Now and then a long burst runs with no gaps at all.
  // ---------------------------------------------------------------------------
  int          burst_left = 0;
  int          items_sent = 0;
  int          sent_ops [4] = '{default: 0};
  logic [63:0] tracked [$];   // cleaned addresses the engine should now hold

  task automatic send_item(input logic [1:0] op, input logic [63:0] w,
                           input logic [11:0] ix);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.word <= w;
    req_ch.entry_index <= ix;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    sent_ops[op]++;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [11:0] rand_index();
    return 12'($urandom());
  endfunction

  // fields an op does not use are filled with noise
  task automatic clear_table();
    send_item(OP_CLEAR, rand_word(), rand_index());
    tracked.delete();
  endtask

  task automatic load_addr(input logic [63:0] w);
    send_item(OP_LOAD, w, rand_index());
    if (tracked.size() < TABLE_DEPTH) tracked.push_back(w & TAG_MASK);
  endtask

  task automatic probe(input logic [63:0] w);
    send_item(OP_PROBE, w, rand_index());
  endtask

  task automatic read_entry(input logic [11:0] ix);
    send_item(OP_READ, rand_word(), ix);
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after a long spell with no item moving either way.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("stalled for %0d cycles with %0d results outstanding", idle, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] base, span, a;
    int          kind, n, m, sel, k, random_from, sessions;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_CLEAR;
    req_ch.word = '0;
    req_ch.entry_index = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table: probe misses, read is out of range
    probe(64'h0);
    read_entry(12'd0);
    // tag bits dropped on load; a duplicate; the top address
    load_addr(64'h3);
    load_addr(64'h1005);
    load_addr(64'h1006);
    load_addr(64'hFFFF_FFFF_FFFF_FFFF);
    probe(64'h1);                    // first entry
    probe(64'h1007);                 // duplicate run, last copy wins
    probe(64'h1008);                 // inside the range, no match
    probe(64'hFFFF_FFFF_FFFF_FFFF);  // last entry
    read_entry(12'd2);
    read_entry(12'd1);
    read_entry(12'd4);
    read_entry(12'hFFF);
    clear_table();
    // stale addresses behind a zero count must not be found
    read_entry(12'd0);
    probe(64'h1004);
    // unsorted loads: the search runs blind over them
    load_addr(64'h8000_0000_0000_0000);
    load_addr(64'h13);
    load_addr(64'h9000_0000_0000_0002);
    probe(64'h10);
    probe(64'h8800_0000_0000_0000);
    probe(64'h9000_0000_0000_0001);
    read_entry(12'd2);

    // random sessions: mostly a clear, a well-formed sorted load and a run of
    // probes aimed at what was loaded; some appending, unsorted and noisy ones
    random_from = items_sent;
    sessions = 0;
    while (items_sent - random_from < RANDOM_ITEMS) begin
      sessions++;
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      if ($urandom_range(0, 7) != 0 || tracked.size() + n > TABLE_DEPTH)
        clear_table();
      base = rand_word() & TAG_MASK;
      span = 64'hFFFF_FFFF_FFFF_FFFF / 64'(n + 1);
      for (int j = 0; j < n; j++) begin
        if (kind <= 4) begin
          a = base;
          base += 64'(4 * $urandom_range(1, 16));
        end else if (kind <= 7) begin
          // spread over the whole address space, still ascending
          a = 64'(j) * span + (rand_word() % span);
          if (j == 0 && $urandom_range(0, 3) == 0) a = 64'h0;
          if (j == n - 1 && $urandom_range(0, 3) == 0) a = 64'hFFFF_FFFF_FFFF_FFFF;
        end else if (kind == 8) begin
          a = base;
          base += 64'(4 * $urandom_range(0, 2));
        end else begin
          a = rand_word();
        end
        load_addr(a | 64'($urandom_range(0, 3)));
      end
      m = $urandom_range(10, 50);
      for (int j = 0; j < m; j++) begin
        sel = $urandom_range(0, 99);
        if (sel < 62 && tracked.size() == 0) begin
          probe(rand_word());
        end else if (sel < 50) begin
          k = $urandom_range(0, tracked.size() - 1);
          probe(tracked[k] | 64'($urandom_range(0, 3)));
        end else if (sel < 62) begin
          // neighbour of a loaded address
          k = $urandom_range(0, tracked.size() - 1);
          a = ($urandom_range(0, 1) != 0) ? tracked[k] + 64'd4 : tracked[k] - 64'd4;
          probe(a | 64'($urandom_range(0, 3)));
        end else if (sel < 70) begin
          probe(rand_word());
        end else if (sel < 90) begin
          if (tracked.size() != 0 && $urandom_range(0, 3) != 0)
            read_entry(12'($urandom_range(0, tracked.size() - 1)));
          else
            read_entry(rand_index());
        end else if (sel < 96) begin
          if (tracked.size() < TABLE_DEPTH) load_addr(rand_word());
          else probe(rand_word());
        end else begin
          clear_table();
        end
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d items: %0d clears, %0d loads, %0d probes, %0d reads.", items_sent,
             sent_ops[OP_CLEAR], sent_ops[OP_LOAD], sent_ops[OP_PROBE], sent_ops[OP_READ]);
    $display("Covered edge addresses, unsorted loads and %0d random table sessions.",
             sessions);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
